### design/wpm_pkg.sv
// Package for the wildcard pattern matcher: item types, symbol codes and defaults.
// Has no dependencies; the matcher unit refers to it by scoped names.
package wpm_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FEED = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] symbol;
        logic       first;
    } wpm_req_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } wpm_rsp_t;

endpackage

### design/wpm_stream_if.sv
// Valid/ready channel interface carrying one item per handshake.
// The payload type is a parameter; the matcher uses the item types of wpm_pkg.
interface wpm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/wildcard_pattern_matcher_unit.sv
// Wildcard pattern matcher: an input register, one pass of match logic, a result register.
// An accepted item waits in the input register until the result register is free, then its result is registered.
// Throughput: one item per cycle unless the output side stalls; the column update is a parallel-prefix carry network.
// Reset (rst_n, asynchronous, active low) empties the pattern and the channels;
// the pattern symbol store itself is not cleared and is only read below the pattern length.
module wildcard_pattern_matcher_unit #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    wpm_stream_if.sink   request,
    wpm_stream_if.source response
);

    // Length and count registers must hold PATTERN_MAX itself. The match column has
    // one bit for every pattern prefix, the empty prefix included, so it is indexed
    // by exactly the bits of the length.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int COL_W = PATTERN_MAX + 1;
    localparam int LVLS  = $clog2(COL_W);

    // Input stage: the accepted item waits here until the result register is free.
    wpm_pkg::wpm_req_t item_reg;
    logic              item_valid_reg;

    // Result stage.
    wpm_pkg::wpm_rsp_t rsp_reg;
    logic              rsp_valid_reg;

    // Pattern state.
    logic [7:0]       store_reg [PATTERN_MAX];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] lsc_reg;
    logic             star_open_reg;
    logic             ovf_reg;
    logic [COL_W-1:0] col_reg;

    // Next values, applied when the item in the input stage moves on.
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] lsc_next;
    logic             star_open_next;
    logic             ovf_next;
    logic [COL_W-1:0] col_next;
    logic             matched_next;

    logic             advance;
    logic             is_load;
    logic             full;
    logic             store_wr;
    logic [LEN_W-1:0] ld_len_base;
    logic [LEN_W-1:0] ld_lsc_base;
    logic             ld_open_base;
    logic             ld_ovf_base;
    logic             sym_is_star;
    logic [LEN_W-1:0] lsc_sel;
    logic [COL_W-1:0] empty_col;
    logic [COL_W-1:0] col_base;
    logic [COL_W-1:0] feed_col;

    // The item in the input stage moves on whenever the result register is empty
    // or its item is being taken in this cycle. A new item is accepted in the same
    // cycle, so items flow at one per cycle unless the output side stalls.
    assign advance       = item_valid_reg && (!rsp_valid_reg || response.ready);
    assign request.ready = !item_valid_reg || advance;

    assign response.valid = rsp_valid_reg;
    assign response.data  = rsp_reg;

    // Pattern load: a first symbol starts a new pattern before storing. A symbol
    // arriving when the store is already full is dropped and the overflow flag set.
    // The leading star count grows only while every stored symbol so far is a star.
    always_comb
    begin
        is_load      = item_reg.operation == wpm_pkg::OP_LOAD;
        sym_is_star  = item_reg.symbol == wpm_pkg::SYM_STAR;
        ld_len_base  = item_reg.first ? '0 : len_reg;
        ld_lsc_base  = item_reg.first ? '0 : lsc_reg;
        ld_open_base = item_reg.first ? 1'b1 : star_open_reg;
        ld_ovf_base  = item_reg.first ? 1'b0 : ovf_reg;
        full         = ld_len_base >= LEN_W'(PATTERN_MAX);
        store_wr     = advance && is_load && !full;

        if (is_load)
        begin
            len_next       = full ? ld_len_base : ld_len_base + LEN_W'(1);
            lsc_next       = (!full && ld_open_base && sym_is_star) ?
                             ld_lsc_base + LEN_W'(1) : ld_lsc_base;
            star_open_next = full ? ld_open_base : (ld_open_base && sym_is_star);
            ovf_next       = ld_ovf_base || full;
        end
        else
        begin
            len_next       = len_reg;
            lsc_next       = lsc_reg;
            star_open_next = star_open_reg;
            ovf_next       = ovf_reg;
        end
    end

    // Column for the empty text: every prefix made only of leading stars matches.
    // A load uses the star count after the load, a text restart the current one.
    always_comb
    begin
        lsc_sel = is_load ? lsc_next : lsc_reg;
        for (int i = 0; i < COL_W; i++)
        begin
            empty_col[i] = LEN_W'(i) <= lsc_sel;
        end
    end

    // Text symbol: column bit i becomes
    //   column[i-1] (old)      when pattern symbol i-1 equals the text symbol or is '?',
    //   column[i] (old) or new bit i-1 when pattern symbol i-1 is '*',
    //   zero otherwise.
    // The equality test comes first, so a star in the text facing a star in the
    // pattern consumes exactly one symbol. The star rule chains upwards through runs
    // of stars; this is a carry chain with generate g and propagate p, resolved by a
    // parallel-prefix network of LVLS levels. Bits beyond the pattern length are
    // forced to zero, and bit zero always clears after a text symbol.
    always_comb
    begin
        logic [COL_W-1:0] g_v;
        logic [COL_W-1:0] p_v;
        logic             act;
        logic             lit;
        logic             star;

        col_base = item_reg.first ? empty_col : col_reg;
        g_v      = '0;
        p_v      = '0;
        for (int i = 1; i < COL_W; i++)
        begin
            act    = LEN_W'(i) <= len_reg;
            lit    = (store_reg[i-1] == item_reg.symbol) ||
                     (store_reg[i-1] == wpm_pkg::SYM_ANY);
            star   = store_reg[i-1] == wpm_pkg::SYM_STAR;
            g_v[i] = act && (lit ? col_base[i-1] : (star && col_base[i]));
            p_v[i] = act && !lit && star;
        end
        for (int k = 0; k < LVLS; k++)
        begin
            g_v = g_v | (p_v & (g_v << (1 << k)));
            p_v = p_v & (p_v << (1 << k));
        end
        feed_col = g_v;
    end

    assign col_next     = is_load ? empty_col : feed_col;
    assign matched_next = col_next[len_next];

    // Control state and the pattern registers that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            len_reg        <= '0;
            lsc_reg        <= '0;
            star_open_reg  <= 1'b1;
            ovf_reg        <= 1'b0;
            col_reg        <= COL_W'(1);
        end
        else
        begin
            if (request.valid && request.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                len_reg       <= len_next;
                lsc_reg       <= lsc_next;
                star_open_reg <= star_open_next;
                ovf_reg       <= ovf_next;
                col_reg       <= col_next;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the symbol store carry no reset.
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            item_reg <= request.data;
        end
        if (advance)
        begin
            rsp_reg.matched          <= matched_next;
            rsp_reg.pattern_overflow <= ovf_next;
        end
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (store_wr && ld_len_base == LEN_W'(i))
            begin
                store_reg[i] <= item_reg.symbol;
            end
        end
    end

    // The stored length never exceeds the capacity of the store.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

    // Leading stars are part of the stored pattern, so they never outnumber it.
    a_lsc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lsc_reg <= len_reg)
        else $error("leading star count exceeds pattern length");

    // Symbols are only dropped once the store is full.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> len_reg == LEN_W'(PATTERN_MAX))
        else $error("overflow flagged with room in the store");

    // The matcher state moves only when an item passes into the result register.
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(col_reg) && $stable(len_reg))
        else $error("match state changed without an item moving on");

endmodule
